// File: design/assert_macros.svh
// Assertion macros, included by the two-class queue design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Implication that must hold outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/tcfsd_pkg.sv
`timescale 1ns / 1ps

package tcfsd_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ENQ     = 2'd0,
        CMD_DEQ_ANY = 2'd1,
        CMD_DEQ_CAT = 2'd2,
        CMD_DEQ_DOG = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_UNUSED = 2'd3
    } t_status;

    typedef struct packed {
        logic                    cls;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic enq;
        logic deq;
        logic any;
        logic want;
    } t_cell_ctl;

endpackage

// File: design/tcfsd_cell.sv
`timescale 1ns / 1ps

module tcfsd_cell (
    input  logic                i_clk,
    input  tcfsd_pkg::t_cell_ctl i_ctl,
    input  logic                i_occ,
    input  logic                i_tail,
    input  tcfsd_pkg::t_entry   i_new,
    input  tcfsd_pkg::t_entry   i_next,
    input  logic                i_found,
    input  tcfsd_pkg::t_entry   i_pick,
    output logic                o_found,
    output tcfsd_pkg::t_entry   o_pick,
    output tcfsd_pkg::t_entry   o_ent
);

    tcfsd_pkg::t_entry r_ent;
    logic              w_match;
    logic              w_first;

    always_comb begin
        w_match        = i_occ & (i_ctl.any | (r_ent.cls == i_ctl.want));
        w_first        = w_match & ~i_found;
        o_found        = i_found | w_match;
        o_pick.cls     = i_pick.cls | (w_first & r_ent.cls);
        o_pick.payload = i_pick.payload
                       | ({tcfsd_pkg::PAYLOAD_BITS{w_first}} & r_ent.payload);
        o_ent          = r_ent;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.enq && i_tail) begin
            r_ent <= i_new;
        end else if (i_ctl.deq && o_found) begin
            r_ent <= i_next;
        end
    end

endmodule

// File: design/two_class_fifo_selective_dequeue.sv
`timescale 1ns / 1ps
// Two-class queue with oldest-of-class removal, built as a row of entry cells.
// Request channel: i_valid/o_ready with i_command, i_item_class, i_item_payload.
// Commands enqueue at the tail, remove the oldest entry, or remove the oldest
// entry of class 0 or class 1; younger entries close the gap in the same cycle.
// Result channel: o_valid/i_ready, one result per request, carrying
// o_result_valid, o_out_class, o_out_payload, o_status and o_now_empty.
// The result is registered at the edge that accepts the request. Throughput is
// one request per cycle while results are taken; the compare in every cell and
// the found/pick chain across the row all settle within that cycle.
// A request is taken while the result register is empty or being drained in
// the same cycle, so a stalled receiver holds the result and stops further
// requests until it is taken.
// Reset empties the queue and the result register; entry contents are not
// cleared and are never read before being written.
`include "assert_macros.svh"

module two_class_fifo_selective_dequeue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_command,
    input  logic                                i_item_class,
    input  logic [tcfsd_pkg::PAYLOAD_BITS-1:0]  i_item_payload,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_result_valid,
    output logic                                o_out_class,
    output logic [tcfsd_pkg::PAYLOAD_BITS-1:0]  o_out_payload,
    output logic [1:0]                          o_status,
    output logic                                o_now_empty
);

    localparam int DEPTH = tcfsd_pkg::DEPTH;
    localparam int CNT_W = tcfsd_pkg::CNT_W;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic                    r_res_valid;
    logic                    r_res_class;
    logic [tcfsd_pkg::PAYLOAD_BITS-1:0] r_res_payload;
    tcfsd_pkg::t_status      r_res_status;
    logic                    r_res_empty;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_hit;
    tcfsd_pkg::t_cmd         w_cmd;
    tcfsd_pkg::t_cell_ctl    w_ctl;
    tcfsd_pkg::t_entry       w_new;
    tcfsd_pkg::t_status      w_status;
    logic                    w_res_valid;
    logic [DEPTH-1:0]        w_occ;
    logic [DEPTH-1:0]        w_tail;
    logic [DEPTH:0]          w_found;
    tcfsd_pkg::t_entry       w_pick [DEPTH+1];
    tcfsd_pkg::t_entry       w_ent  [DEPTH];

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_cmd    = tcfsd_pkg::t_cmd'(i_command);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_new    = '{cls: i_item_class, payload: i_item_payload};

    always_comb begin
        w_ctl.enq  = w_accept && (w_cmd == tcfsd_pkg::CMD_ENQ) && !w_full;
        w_ctl.deq  = w_accept && (w_cmd != tcfsd_pkg::CMD_ENQ);
        w_ctl.any  = (w_cmd == tcfsd_pkg::CMD_DEQ_ANY);
        w_ctl.want = (w_cmd == tcfsd_pkg::CMD_DEQ_DOG);
    end

    assign w_found[0] = 1'b0;
    assign w_pick[0]  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_occ[g]  = (r_count > CNT_W'(g));
        assign w_tail[g] = (r_count == CNT_W'(g));

        tcfsd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_occ   (w_occ[g]),
            .i_tail  (w_tail[g]),
            .i_new   (w_new),
            .i_next  ((g == DEPTH - 1) ? w_new : w_ent[(g + 1) % DEPTH]),
            .i_found (w_found[g]),
            .i_pick  (w_pick[g]),
            .o_found (w_found[g+1]),
            .o_pick  (w_pick[g+1]),
            .o_ent   (w_ent[g])
        );
    end

    assign w_hit = w_found[DEPTH];

    always_comb begin
        n_count     = r_count;
        w_status    = tcfsd_pkg::ST_OK;
        w_res_valid = 1'b0;
        if (w_cmd == tcfsd_pkg::CMD_ENQ) begin
            if (w_full) begin
                w_status = tcfsd_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (w_hit) begin
            w_res_valid = 1'b1;
            n_count     = r_count - CNT_W'(1);
        end else begin
            w_status = tcfsd_pkg::ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_valid   <= w_res_valid;
            r_res_class   <= w_res_valid & w_pick[DEPTH].cls;
            r_res_payload <= {tcfsd_pkg::PAYLOAD_BITS{w_res_valid}}
                           & w_pick[DEPTH].payload;
            r_res_status  <= w_status;
            r_res_empty   <= (n_count == '0);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_valid = r_res_valid;
    assign o_out_class    = r_res_class;
    assign o_out_payload  = r_res_payload;
    assign o_status       = r_res_status;
    assign o_now_empty    = r_res_empty;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_enq_grows, i_clk, i_rst_n, w_ctl.enq, r_count == $past(r_count) + CNT_W'(1))
    `ASSERT_IMPLY(a_valid_ok, i_clk, i_rst_n, r_out_valid && r_res_valid, r_res_status == tcfsd_pkg::ST_OK)
    `ASSERT_IMPLY(a_empty_match, i_clk, i_rst_n, r_out_valid, r_res_empty == (r_count == '0))

endmodule

// File: sim/two_class_fifo_selective_dequeue_tb.sv
`timescale 1ns / 1ps

module two_class_fifo_selective_dequeue_tb;

    localparam int IDLE_PCT       = 22;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASES         = 9;
    localparam int PHASE_REQUESTS = 100;
    localparam int PAY_W          = tcfsd_pkg::PAYLOAD_BITS;

    typedef struct packed {
        logic                 removed;
        logic                 cls;
        logic [PAY_W-1:0]     payload;
        tcfsd_pkg::t_status   status;
        logic                 now_empty;
    } t_pet_result;

    class pet_queue_scoreboard;
        tcfsd_pkg::t_entry held[$];
        t_pet_result       owed[$];
        int                mismatches;
        int                requests_noted;
        int                results_seen;
        int                full_rejects;
        int                missed_dequeues;
        int                middle_removals;

        function void note_request(tcfsd_pkg::t_cmd cmd, logic cls, logic [PAY_W-1:0] pay);
            t_pet_result       res;
            tcfsd_pkg::t_entry fresh;
            int                hit;
            res = '0;
            res.status = tcfsd_pkg::ST_OK;
            hit = -1;
            requests_noted++;
            if (cmd == tcfsd_pkg::CMD_ENQ) begin
                if (held.size() >= tcfsd_pkg::DEPTH) begin
                    res.status = tcfsd_pkg::ST_FULL;
                    full_rejects++;
                end else begin
                    fresh.cls = cls;
                    fresh.payload = pay;
                    held.push_back(fresh);
                end
            end else begin
                if (cmd == tcfsd_pkg::CMD_DEQ_ANY) begin
                    if (held.size() > 0) begin
                        hit = 0;
                    end
                end else begin
                    for (int i = 0; i < held.size(); i++) begin
                        if (held[i].cls == (cmd == tcfsd_pkg::CMD_DEQ_DOG) && hit < 0) begin
                            hit = i;
                        end
                    end
                end
                if (hit >= 0) begin
                    res.removed = 1'b1;
                    res.cls = held[hit].cls;
                    res.payload = held[hit].payload;
                    if (hit > 0 && hit < held.size() - 1) begin
                        middle_removals++;
                    end
                    held.delete(hit);
                end else begin
                    res.status = tcfsd_pkg::ST_NONE;
                    missed_dequeues++;
                end
            end
            res.now_empty = (held.size() == 0);
            owed.push_back(res);
        endfunction

        task report_mismatch(string what, logic [PAY_W-1:0] got,
                             logic [PAY_W-1:0] want);
            if (mismatches < 20) begin
                $display("MISMATCH result %0d: %s got %h expected %h",
                         results_seen, what, got, want);
            end
            mismatches++;
        endtask

        task check_result(logic removed, logic cls, logic [PAY_W-1:0] pay,
                          logic [1:0] st, logic empty);
            t_pet_result want;
            results_seen++;
            if (owed.size() == 0) begin
                report_mismatch("unexpected result", pay, '0);
            end else begin
                want = owed[0];
                owed.delete(0);
                if (removed !== want.removed) begin
                    report_mismatch("result_valid", PAY_W'(removed), PAY_W'(want.removed));
                end
                if (cls !== want.cls) begin
                    report_mismatch("out_class", PAY_W'(cls), PAY_W'(want.cls));
                end
                if (pay !== want.payload) begin
                    report_mismatch("out_payload", pay, want.payload);
                end
                if (st !== want.status) begin
                    report_mismatch("status", PAY_W'(st), PAY_W'(want.status));
                end
                if (empty !== want.now_empty) begin
                    report_mismatch("now_empty", PAY_W'(empty), PAY_W'(want.now_empty));
                end
            end
        endtask

        task wrap_up();
            while (owed.size() > 0) begin
                report_mismatch("missing result", '0, owed[0].payload);
                owed.delete(0);
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [1:0]              i_command;
    logic                    i_item_class;
    logic [PAY_W-1:0]        i_item_payload;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_result_valid;
    logic                    o_out_class;
    logic [PAY_W-1:0]        o_out_payload;
    logic [1:0]              o_status;
    logic                    o_now_empty;

    pet_queue_scoreboard queue_score = new();
    logic                quiet = 1'b0;
    logic                hold_off_now = 1'b0;
    int                  stall_cycles = 0;

    two_class_fifo_selective_dequeue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_item_class   (i_item_class),
        .i_item_payload (i_item_payload),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_valid (o_result_valid),
        .o_out_class    (o_out_class),
        .o_out_payload  (o_out_payload),
        .o_status       (o_status),
        .o_now_empty    (o_now_empty)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_request(tcfsd_pkg::t_cmd cmd, logic cls, logic [PAY_W-1:0] pay);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_item_class   <= cls;
        i_item_payload <= pay;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        queue_score.note_request(cmd, cls, pay);
        @(negedge i_clk);
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_now) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_now = 1'b0;
            end
            if (!quiet && $urandom_range(99) < IDLE_PCT) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            queue_score.check_result(o_result_valid, o_out_class, o_out_payload,
                                     o_status, o_now_empty);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog expired after %0d cycles without progress.", stall_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int                enq_share[PHASES];
        int                dog_share[PHASES];
        tcfsd_pkg::t_cmd   cmd;
        logic              cls;
        logic [PAY_W-1:0]  pay;

        enq_share      = '{80, 20, 60, 95, 50, 10, 70, 30, 50};
        dog_share      = '{50, 0, 100, 50, 20, 80, 50, 100, 0};
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = tcfsd_pkg::CMD_ENQ;
        i_item_class   = 1'b0;
        i_item_payload = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(tcfsd_pkg::CMD_DEQ_ANY, 1'b1, '1);
        send_request(tcfsd_pkg::CMD_DEQ_CAT, 1'b0, '0);
        send_request(tcfsd_pkg::CMD_DEQ_DOG, 1'b1, $urandom);
        for (int i = 0; i < tcfsd_pkg::DEPTH; i++) begin
            cls = (i >= 3) && (i % 2 == 1);
            pay = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
            send_request(tcfsd_pkg::CMD_ENQ, cls, pay);
        end
        send_request(tcfsd_pkg::CMD_ENQ, 1'b1, 32'hA5A5_5A5A);
        send_request(tcfsd_pkg::CMD_DEQ_DOG, 1'b0, '0);
        send_request(tcfsd_pkg::CMD_DEQ_CAT, 1'b1, '1);
        send_request(tcfsd_pkg::CMD_DEQ_ANY, 1'b0, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            quiet = (phase == 4);
            if (phase == 2) begin
                hold_off_now = 1'b1;
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if ($urandom_range(99) < enq_share[phase]) begin
                    cmd = tcfsd_pkg::CMD_ENQ;
                end else begin
                    case ($urandom_range(2))
                        0: cmd = tcfsd_pkg::CMD_DEQ_ANY;
                        1: cmd = tcfsd_pkg::CMD_DEQ_CAT;
                        default: cmd = tcfsd_pkg::CMD_DEQ_DOG;
                    endcase
                end
                cls = ($urandom_range(99) < dog_share[phase]);
                case ($urandom_range(15))
                    0: pay = '0;
                    1: pay = '1;
                    default: pay = $urandom;
                endcase
                send_request(cmd, cls, pay);
            end
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (queue_score.owed.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        queue_score.wrap_up();

        $display("Covered %0d requests and %0d results, including %0d rejected enqueues,",
                 queue_score.requests_noted, queue_score.results_seen,
                 queue_score.full_rejects);
        $display("%0d dequeues that found nothing and %0d removals from inside the queue.",
                 queue_score.missed_dequeues, queue_score.middle_removals);
        if (queue_score.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
